>>> src/tsst_pkg.sv
// Package with the sizes, codes and types shared by the two-scope symbol table.
package tsst_pkg;

    // Number of entries in each of the two tables.
    localparam int TABLE_DEPTH = 128;
    // Address bits for one table and bits of a fill count that can hold the depth itself.
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    localparam int NAME_W  = 8;
    localparam int VALUE_W = 32;
    localparam int WORD_W  = NAME_W + VALUE_W;

    // Command codes of the action field.
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Status codes of a result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_UNDEF = 2'd3;

    // The empty name.
    localparam logic [NAME_W-1:0] NAME_EMPTY = '0;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

>>> src/two_scope_symbol_table.sv
// Top level of the two-scope symbol table: sequencer and the two table memories.
//
// Usage: commands arrive on the input channel (in_valid/in_ready) with the fields
// action, scope_local, sym_name and value. Every command gives exactly one result
// on the output channel (out_valid/out_ready) with read_value and status.
// A set or get walks a table memory one entry per cycle, comparing each entry in
// the cycle after its read because the memory read is registered. The walk ends
// on the first matching name or at the table's fill count. Clear, an empty name
// and an unused code skip the walk; a get from the local scope walks the local
// table and then the global one. The block takes one command at a time; the walk
// over the memory sets the throughput.
// The result sits in an output register, so the next command is accepted while
// an earlier result still waits for out_ready; a finished command that finds
// the output register occupied waits there until the receiver takes it.
// Reset empties both tables at once by clearing the fill counts; the memory
// contents themselves are not cleared and no clearing pass is needed.
module two_scope_symbol_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic                         scope_local,
    input  logic [tsst_pkg::NAME_W-1:0]  sym_name,
    input  logic signed [tsst_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [tsst_pkg::VALUE_W-1:0] read_value,
    output logic [1:0]                   status
);
    import tsst_pkg::*;

    // Table memories: each word holds a name above its value.
    logic [WORD_W-1:0] g_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] l_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] g_rdata_reg;
    logic [WORD_W-1:0] l_rdata_reg;

    // Control and command registers.
    state_t               state_reg, state_next;
    logic [FILL_W-1:0]    g_fill_reg, g_fill_next;
    logic [FILL_W-1:0]    l_fill_reg, l_fill_next;
    logic [FILL_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic                 pend_reg, pend_next;
    logic                 tbl_reg, tbl_next;
    logic [1:0]           op_reg, op_next;
    logic [NAME_W-1:0]    name_reg, name_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic                 append_reg, append_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    logic [VALUE_W-1:0]   res_val_reg, res_val_next;
    logic [1:0]           res_st_reg, res_st_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_val_reg, out_val_next;
    logic [1:0]           out_st_reg, out_st_next;

    // Memory access controls.
    logic                 rd_en;
    logic                 g_we;
    logic                 l_we;

    // Scan helpers.
    logic [WORD_W-1:0]    cur_rdata;
    logic [FILL_W-1:0]    cur_fill;
    logic                 hit;
    logic                 more;
    logic                 slot_free;

    assign cur_rdata = tbl_reg ? l_rdata_reg : g_rdata_reg;
    assign cur_fill  = tbl_reg ? l_fill_reg : g_fill_reg;
    assign hit       = pend_reg && (cur_rdata[WORD_W-1:VALUE_W] == name_reg);
    assign more      = addr_reg < cur_fill;
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_value = out_val_reg;
    assign status     = out_st_reg;

    // Sequencer: accept, walk the tables, then hand the result to the output register.
    always_comb
    begin
        state_next     = state_reg;
        g_fill_next    = g_fill_reg;
        l_fill_next    = l_fill_reg;
        addr_next      = addr_reg;
        pidx_next      = pidx_reg;
        pend_next      = 1'b0;
        tbl_next       = tbl_reg;
        op_next        = op_reg;
        name_next      = name_reg;
        val_next       = val_reg;
        wr_pend_next   = wr_pend_reg;
        append_next    = append_reg;
        wr_idx_next    = wr_idx_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        rd_en          = 1'b0;
        g_we           = 1'b0;
        l_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = action;
                    name_next    = sym_name;
                    val_next     = value;
                    tbl_next     = scope_local;
                    addr_next    = '0;
                    wr_pend_next = 1'b0;
                    append_next  = 1'b0;
                    res_val_next = '0;
                    res_st_next  = ST_OK;
                    state_next   = S_DONE;
                    if (action == ACT_CLEAR)
                    begin
                        g_fill_next = '0;
                        l_fill_next = '0;
                    end
                    else if (action inside {ACT_SET, ACT_GET})
                    begin
                        if (sym_name == NAME_EMPTY)
                        begin
                            res_st_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    // Found the name in the table under search.
                    res_st_next = ST_OK;
                    if (op_reg == ACT_SET)
                    begin
                        wr_pend_next = 1'b1;
                        wr_idx_next  = pidx_reg;
                    end
                    else
                    begin
                        res_val_next = cur_rdata[VALUE_W-1:0];
                    end
                    state_next = S_DONE;
                end
                else if (more)
                begin
                    // Read the next entry; it is compared in the following cycle.
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = addr_reg[IDX_W-1:0];
                    addr_next = FILL_W'(addr_reg + 1'b1);
                end
                else if (op_reg == ACT_GET && tbl_reg)
                begin
                    // Not in the local table: go on with the global one.
                    tbl_next  = 1'b0;
                    addr_next = '0;
                end
                else if (op_reg == ACT_GET)
                begin
                    res_st_next = ST_UNDEF;
                    state_next  = S_DONE;
                end
                else if (cur_fill >= FILL_W'(TABLE_DEPTH))
                begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    // New name goes after the last filled entry.
                    res_st_next  = ST_OK;
                    wr_pend_next = 1'b1;
                    append_next  = 1'b1;
                    wr_idx_next  = cur_fill[IDX_W-1:0];
                    state_next   = S_DONE;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_st_next    = res_st_reg;
                    g_we           = wr_pend_reg && !tbl_reg;
                    l_we           = wr_pend_reg && tbl_reg;
                    if (append_reg && tbl_reg)
                    begin
                        l_fill_next = FILL_W'(l_fill_reg + 1'b1);
                    end
                    else if (append_reg)
                    begin
                        g_fill_next = FILL_W'(g_fill_reg + 1'b1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            g_fill_reg    <= '0;
            l_fill_reg    <= '0;
            pend_reg      <= 1'b0;
            wr_pend_reg   <= 1'b0;
            append_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g_fill_reg    <= g_fill_next;
            l_fill_reg    <= l_fill_next;
            pend_reg      <= pend_next;
            wr_pend_reg   <= wr_pend_next;
            append_reg    <= append_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        pidx_reg    <= pidx_next;
        tbl_reg     <= tbl_next;
        op_reg      <= op_next;
        name_reg    <= name_next;
        val_reg     <= val_next;
        wr_idx_reg  <= wr_idx_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    // Global table memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            g_mem[wr_idx_reg] <= {name_reg, val_reg};
        end
        if (rd_en)
        begin
            g_rdata_reg <= g_mem[addr_reg[IDX_W-1:0]];
        end
    end

    // Local table memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            l_mem[wr_idx_reg] <= {name_reg, val_reg};
        end
        if (rd_en)
        begin
            l_rdata_reg <= l_mem[addr_reg[IDX_W-1:0]];
        end
    end

endmodule

>>> bench/tb_two_scope_symbol_table.sv
// Testbench for the two-scope symbol table: scoreboarded set, get and clear traffic.
module tb_two_scope_symbol_table;

    timeunit 1ns;
    timeprecision 1ps;

    import tsst_pkg::*;

    // The action code that the block leaves unused.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [1:0]                status;
    } answer_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                action;
    logic                      scope_local;
    logic [NAME_W-1:0]         sym_name;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [VALUE_W-1:0] read_value;
    logic [1:0]                status;

    // Shadow copy of both tables, kept in step with accepted commands.
    logic [NAME_W-1:0]         glb_names [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] glb_vals  [TABLE_DEPTH];
    logic [NAME_W-1:0]         loc_names [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] loc_vals  [TABLE_DEPTH];
    int                        glb_fill;
    int                        loc_fill;

    answer_t lookup_answers[$];
    int      err_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    two_scope_symbol_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .scope_local (scope_local),
        .sym_name    (sym_name),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Position of a name among the filled entries of one table, or -1.
    function automatic int find_slot(input bit in_local, input logic [NAME_W-1:0] nm);
        int fill;
        fill = in_local ? loc_fill : glb_fill;
        for (int i = 0; i < fill; i++)
        begin
            if ((in_local ? loc_names[i] : glb_names[i]) == nm)
                return i;
        end
        return -1;
    endfunction

    // Computes the answer to one command and applies its effect to the shadow tables.
    function automatic answer_t predict_answer(input logic [1:0] act, input logic sc,
                                               input logic [NAME_W-1:0] nm,
                                               input logic signed [VALUE_W-1:0] val);
        answer_t ans;
        int      idx;
        ans.read_value = '0;
        ans.status     = ST_OK;
        idx            = -1;
        case (act)
            ACT_SET:
            begin
                if (nm == NAME_EMPTY)
                    ans.status = ST_EMPTY;
                else
                begin
                    idx = find_slot(sc, nm);
                    if (idx >= 0)
                    begin
                        if (sc)
                            loc_vals[idx] = val;
                        else
                            glb_vals[idx] = val;
                    end
                    else if ((sc ? loc_fill : glb_fill) >= TABLE_DEPTH)
                        ans.status = ST_FULL;
                    else if (sc)
                    begin
                        loc_names[loc_fill] = nm;
                        loc_vals[loc_fill]  = val;
                        loc_fill++;
                    end
                    else
                    begin
                        glb_names[glb_fill] = nm;
                        glb_vals[glb_fill]  = val;
                        glb_fill++;
                    end
                end
            end
            ACT_GET:
            begin
                if (nm == NAME_EMPTY)
                    ans.status = ST_EMPTY;
                else
                begin
                    // The local table shadows the global one when its scope is active.
                    if (sc)
                    begin
                        idx = find_slot(1'b1, nm);
                        if (idx >= 0)
                            ans.read_value = loc_vals[idx];
                    end
                    if (idx < 0)
                    begin
                        idx = find_slot(1'b0, nm);
                        if (idx >= 0)
                            ans.read_value = glb_vals[idx];
                        else
                            ans.status = ST_UNDEF;
                    end
                end
            end
            ACT_CLEAR:
            begin
                glb_fill = 0;
                loc_fill = 0;
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Sends one command transaction and records its expected answer on acceptance.
    task automatic send_command(input logic [1:0] act, input logic sc,
                                input logic [NAME_W-1:0] nm,
                                input logic signed [VALUE_W-1:0] val);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        scope_local <= sc;
        sym_name    <= nm;
        value       <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lookup_answers.push_back(predict_answer(act, sc, nm, val));
    endtask

    // Holds the sender off until every outstanding answer has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (lookup_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return NAME_EMPTY;
        else if (r < 64)
            return NAME_W'($urandom_range(16, 1));
        else
            return NAME_W'($urandom_range(255, 1));
    endfunction

    // Extremes of the fields, scope shadowing, updates, clear and the unused code.
    task automatic test_directed();
        send_command(ACT_GET,    1'b0, 8'h41, '0);
        send_command(ACT_GET,    1'b1, NAME_EMPTY, '0);
        send_command(ACT_SET,    1'b0, NAME_EMPTY, 32'sh1234_5678);
        send_command(ACT_SET,    1'b0, 8'hff, 32'sh7fff_ffff);
        send_command(ACT_SET,    1'b1, 8'h01, 32'sh8000_0000);
        send_command(ACT_GET,    1'b1, 8'h01, '0);
        send_command(ACT_GET,    1'b0, 8'h01, '0);
        send_command(ACT_SET,    1'b0, 8'h01, '1);
        send_command(ACT_GET,    1'b1, 8'h01, '0);
        send_command(ACT_GET,    1'b0, 8'h01, '0);
        send_command(ACT_GET,    1'b1, 8'hff, '0);
        send_command(ACT_SET,    1'b0, 8'hff, '0);
        send_command(ACT_GET,    1'b0, 8'hff, '1);
        send_command(ACT_UNUSED, 1'b1, 8'h07, 32'sh0f0f_0f0f);
        send_command(ACT_GET,    1'b0, 8'h07, '0);
        send_command(ACT_CLEAR,  1'b1, 8'h09, 32'sh7fff_ffff);
        send_command(ACT_GET,    1'b1, 8'h01, '0);
        send_command(ACT_GET,    1'b0, 8'hff, '0);
        send_command(ACT_SET,    1'b1, 8'h80, 32'sh5555_aaaa);
        send_command(ACT_GET,    1'b1, 8'h80, '0);
        send_command(ACT_SET,    1'b1, 8'h80, 32'shaaaa_5555);
        send_command(ACT_GET,    1'b1, 8'h80, '0);
        send_command(ACT_CLEAR,  1'b0, NAME_EMPTY, '0);
    endtask

    // Fills both tables to the last entry, then hits the full limit and long searches.
    task automatic test_table_full();
        logic [NAME_W-1:0] perm [255];
        logic [NAME_W-1:0] tmp;
        int                j;
        send_command(ACT_CLEAR, 1'b0, NAME_EMPTY, '0);
        for (int sc = 0; sc < 2; sc++)
        begin
            for (int i = 0; i < 255; i++)
                perm[i] = NAME_W'(i + 1);
            for (int i = 254; i > 0; i--)
            begin
                j       = $urandom_range(i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            for (int i = 0; i < TABLE_DEPTH; i++)
                send_command(ACT_SET, sc[0], perm[i], pick_value());
            // A new name is refused, an existing one is still updated.
            send_command(ACT_SET, sc[0], perm[TABLE_DEPTH], pick_value());
            send_command(ACT_SET, sc[0], perm[TABLE_DEPTH - 1], pick_value());
            send_command(ACT_GET, sc[0], perm[TABLE_DEPTH - 1], '0);
        end
        for (int i = 0; i < 34; i++)
            send_command($urandom_range(1) ? ACT_GET : ACT_SET, 1'($urandom),
                         NAME_W'($urandom_range(255)), pick_value());
    endtask

    // Random mix, weighted toward names that hit earlier sets.
    task automatic test_random_mix(input int count);
        logic [1:0] act;
        int         r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 46)
                act = ACT_SET;
            else if (r < 95)
                act = ACT_GET;
            else if (r < 97)
                act = ACT_CLEAR;
            else
                act = ACT_UNUSED;
            send_command(act, 1'($urandom), pick_name(), pick_value());
        end
    endtask

    // Receiver side: random stalls on out_ready.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each answer transaction with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lookup_answers.size() == 0)
                report_mismatch("answer arrived with no command outstanding");
            else
            begin
                want = lookup_answers.pop_front();
                if (read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %0h expected %0h",
                                              read_value, want.read_value));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              status, want.status));
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_SET;
        scope_local   = 1'b0;
        sym_name      = NAME_EMPTY;
        value         = '0;
        glb_fill      = 0;
        loc_fill      = 0;
        err_count     = 0;
        send_idle_pct = 28;
        recv_idle_pct = 70;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_random_mix(200);
        wait_for_drain();

        send_idle_pct = 70;
        recv_idle_pct = 28;
        test_table_full();
        test_random_mix(200);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(200);
        test_table_full();

        // Let the last answers come back, then allow for a full-table search.
        wait_for_drain();
        repeat (300) @(posedge clk);
        if (lookup_answers.size() != 0)
            report_mismatch("expected answers never arrived");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
src/tsst_pkg.sv
src/two_scope_symbol_table.sv
bench/tb_two_scope_symbol_table.sv
